// ----- hdl/clcd_pkg.sv -----
// shared types, constants and helpers for the character lcd text writer
package clcd_pkg;

  localparam int COLUMNS = 16;
  localparam int ROWS    = 2;
  localparam int COL_W   = $clog2(COLUMNS);

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int INIT_LEN = 8;
  localparam int STEP_W   = $clog2(INIT_LEN);

  localparam logic [1:0] CMD_CHAR = 2'd0;
  localparam logic [1:0] CMD_GOTO = 2'd1;
  localparam logic [1:0] CMD_INIT = 2'd2;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_CHAR_WRAP,
    OP_GOTO,
    OP_INIT
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    logic [7:0] addr;
  } op_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  typedef struct packed {
    logic        reg_select;
    logic [7:0]  bus_byte;
    logic        wait_busy;
    logic [10:0] delay_before;
    logic        last;
  } res_t;

  // set-ddram-address command for a cursor position
  function automatic logic [7:0] addr_byte(input logic r, input logic [COL_W-1:0] c);
    logic [7:0] base;
    base = r ? 8'h40 : 8'h00;
    return 8'(8'h80 + base + 8'(c));
  endfunction

endpackage

// ----- hdl/clcd_front.sv -----
// front end: accepts requests, tracks the cursor and queues bus operations
module clcd_front
  import clcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] char_code,
  input  logic [3:0] col,
  input  logic       row,
  input  qstat_t     qstat,
  output logic       push,
  output op_t        push_op
);

  logic [COL_W-1:0] cursor_col, cursor_col_next;
  logic             cursor_row, cursor_row_next;

  logic [COL_W:0]   col_inc;
  logic             col_wrap;
  logic [1:0]       row_inc;
  logic             row_adv;
  logic [COL_W-1:0] col_sat;
  logic             row_sat;
  logic             accept;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_inc  = {1'b0, cursor_col} + (COL_W+1)'(1);
    col_wrap = col_inc > (COL_W+1)'(COLUMNS - 1);
    row_inc  = {1'b0, cursor_row} + 2'd1;
    row_adv  = (row_inc > 2'(ROWS - 1)) ? 1'b0 : row_inc[0];
    col_sat  = ({4'b0, col} > 8'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : COL_W'(col);
    row_sat  = (row > 1'(ROWS - 1)) ? 1'(ROWS - 1) : row;
  end

  always_comb begin
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    push            = 1'b0;
    push_op.kind    = OP_CHAR;
    push_op.data    = char_code;
    push_op.addr    = 8'h00;
    unique case (cmd)
      CMD_CHAR: begin
        push = accept;
        if (col_wrap) begin
          cursor_col_next = '0;
          cursor_row_next = row_adv;
          push_op.kind    = OP_CHAR_WRAP;
          push_op.addr    = addr_byte(row_adv, '0);
        end else begin
          cursor_col_next = col_inc[COL_W-1:0];
        end
      end
      CMD_GOTO: begin
        push            = accept;
        cursor_col_next = col_sat;
        cursor_row_next = row_sat;
        push_op.kind    = OP_GOTO;
        push_op.addr    = addr_byte(row_sat, col_sat);
      end
      CMD_INIT: begin
        push            = accept;
        cursor_col_next = '0;
        cursor_row_next = 1'b0;
        push_op.kind    = OP_INIT;
      end
      default: begin
        // unused code: dropped, cursor unchanged
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= 1'b0;
    end else if (accept) begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
    end
  end

endmodule

// ----- hdl/clcd_queue.sv -----
// small operation queue between front and back ends
module clcd_queue
  import clcd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  op_t    push_op,
  input  logic   pop,
  output op_t    head,
  output qstat_t qstat
);

  op_t               slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign do_push     = push && (count != QCNT_W'(QDEPTH));
  assign do_pop      = pop && (count != '0);
  assign head        = slots[rd_ptr];
  assign qstat.full  = count == QCNT_W'(QDEPTH);
  assign qstat.empty = count == '0;
  assign qstat.count = count;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/clcd_back.sv -----
// back end: expands queued operations into bus writes, one per cycle while out_ready holds
module clcd_back
  import clcd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  op_t    head,
  input  qstat_t qstat,
  output logic   pop,
  output logic   out_valid,
  input  logic   out_ready,
  output res_t   out_res
);

  logic [STEP_W-1:0] step;
  res_t              res;
  logic              load;

  function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] s);
    logic [7:0] b;
    unique case (s)
      3'd0, 3'd1, 3'd2: b = 8'h30;
      3'd3:             b = 8'h38;
      3'd4:             b = 8'h14;
      3'd5:             b = 8'h0C;
      3'd6:             b = 8'h01;
      default:          b = 8'h06;
    endcase
    return b;
  endfunction

  function automatic logic [10:0] init_delay(input logic [STEP_W-1:0] s);
    logic [10:0] d;
    unique case (s)
      3'd0:             d = 11'd2000;
      3'd1, 3'd2, 3'd3: d = 11'd500;
      default:          d = 11'd0;
    endcase
    return d;
  endfunction

  always_comb begin
    res.reg_select   = 1'b0;
    res.bus_byte     = head.addr;
    res.wait_busy    = 1'b1;
    res.delay_before = 11'd0;
    res.last         = 1'b1;
    unique case (head.kind)
      OP_CHAR: begin
        res.reg_select = 1'b1;
        res.bus_byte   = head.data;
      end
      OP_CHAR_WRAP: begin
        if (step == '0) begin
          res.reg_select = 1'b1;
          res.bus_byte   = head.data;
          res.last       = 1'b0;
        end
      end
      OP_GOTO: begin
        res.bus_byte = head.addr;
      end
      OP_INIT: begin
        res.bus_byte     = init_byte(step);
        res.wait_busy    = step >= STEP_W'(3);
        res.delay_before = init_delay(step);
        res.last         = step == STEP_W'(INIT_LEN - 1);
      end
      default: begin
        res.last = 1'b1;
      end
    endcase
  end

  assign load = !qstat.empty && (!out_valid || out_ready);
  assign pop  = load && res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= res.last ? '0 : step + STEP_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

// ----- hdl/char_lcd_text_writer.sv -----
// top level of the character lcd text writer
// Turns text requests for a 16x2 character LCD into controller bus writes,
// one result transfer per write. The front end takes a request in any cycle
// in which the four-entry operation queue has room, updates the cursor at
// once and queues one operation; the back end expands the queue head into
// bus writes at one per cycle while m_tready holds, through a registered
// output stage: a character is one write, or two when it wraps and an
// address command follows, a goto is one write and an init is eight.
// Unused request code 3 is taken and dropped with no output. tlast marks the
// final write of each request; tuser is 0 for a command register write and
// 1 for a data register write.
module char_lcd_text_writer
  import clcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // char_code[7:0], col[11:8], row[12], zero[15:13]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  // bus write channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // bus_byte[7:0], wait_busy[8], delay_before[19:9],
                                 // zero[23:20]
  output logic        m_tuser,   // reg_select[0]
  output logic        m_tlast
);

  // front to queue
  logic   push;
  op_t    push_op;
  // queue to back
  op_t    head;
  qstat_t qstat;
  logic   pop;
  // registered result
  res_t   out_res;

  clcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cmd       (s_tuser),
    .char_code (s_tdata[7:0]),
    .col       (s_tdata[11:8]),
    .row       (s_tdata[12]),
    .qstat     (qstat),
    .push      (push),
    .push_op   (push_op)
  );

  clcd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .qstat   (qstat)
  );

  clcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // pack the result transfer
  assign m_tdata = {4'b0, out_res.delay_before, out_res.wait_busy, out_res.bus_byte};
  assign m_tuser = out_res.reg_select;
  assign m_tlast = out_res.last;

  // queue occupancy stays within its depth
  assert property (@(posedge clk) disable iff (rst) qstat.count <= QCNT_W'(QDEPTH))
    else $error("operation queue count beyond depth");

  // the front end never pushes into a full queue
  assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("push into full operation queue");

  // a delayed write is always a command register write
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[19:9] != 11'd0)) |-> !m_tuser)
    else $error("delay on a data register write");

endmodule
